// ----- sv/cts_pkg.sv -----
// Shared types and constants for the calorimeter track seed block.
// Depends on nothing; every other file of the block except cts_ram imports it.
package cts_pkg;

  // Field widths of the request and result channels.
  localparam int ACTION_W   = 2;
  localparam int CHANNEL_W  = 11;
  localparam int LAYER_W    = 4;
  localparam int BAR_W      = 5;
  localparam int DYNODE_W   = 4;
  localparam int ADC_W      = 16;
  localparam int MEAN_W     = 20;
  localparam int SIGMA_W    = 16;
  localparam int THRESH_W   = 20;

  // Amplitudes carry 4 fraction bits; one extra bit holds mean + 3 sigma.
  localparam int ADC_FRAC_W = 4;
  localparam int AMP_W      = 21;
  localparam int PED_W      = MEAN_W + SIGMA_W;

  localparam logic [DYNODE_W-1:0] USED_DYNODE  = 4'd8;
  localparam logic [AMP_W-1:0]    SIGMA_FACTOR = 21'd3;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd3200;

  localparam int DEF_NUM_LAYERS   = 14;
  localparam int DEF_NUM_CHANNELS = 2048;
  localparam int DEF_NUM_BARS     = 22;
  localparam int QUEUE_DEPTH      = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_HIT  = 2'd1,
    ACT_END  = 2'd2
  } action_t;

  // Command handed from the front part to the back part through the queue.
  typedef struct packed {
    action_t                kind;
    logic [CHANNEL_W-1:0]   channel;
    logic [LAYER_W-1:0]     layer;
    logic [BAR_W-1:0]       bar;
    logic [ADC_W-1:0]       adc;
    logic [MEAN_W-1:0]      mean;
    logic [SIGMA_W-1:0]     sigma;
  } cmd_t;

endpackage

// ----- sv/cts_if.sv -----
// Request and result channel interfaces of the calorimeter track seed block.
// Depends on cts_pkg for the field widths.
interface cts_item_if;
  import cts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [CHANNEL_W-1:0]  channel;
  logic [LAYER_W-1:0]    layer;
  logic [BAR_W-1:0]      bar;
  logic [DYNODE_W-1:0]   dynode;
  logic                  side;
  logic [ADC_W-1:0]      adc;
  logic [MEAN_W-1:0]     ped_mean;
  logic [SIGMA_W-1:0]    ped_sigma;

  modport source (output valid, action, channel, layer, bar, dynode, side, adc,
                  ped_mean, ped_sigma, input ready);
  modport sink   (input valid, action, channel, layer, bar, dynode, side, adc,
                  ped_mean, ped_sigma, output ready);
endinterface

interface cts_result_if;
  import cts_pkg::*;

  logic                valid;
  logic                ready;
  logic [LAYER_W-1:0]  out_layer;
  logic [BAR_W-1:0]    best_bar;
  logic                track_found;
  logic                last;

  modport source (output valid, out_layer, best_bar, track_found, last, input ready);
  modport sink   (input valid, out_layer, best_bar, track_found, last, output ready);
endinterface

// ----- sv/calorimeter_track_seed_core.sv -----
// Calorimeter track seed: the top level, tying front, queue and back parts
// together and holding the energy threshold register. Depends on cts_pkg,
// cts_if, cts_front, cts_queue, cts_back and cts_ram.
//
// The block takes one request per cycle on items while the command queue has
// room: a pedestal load, a hit or an end of event. A front stage drops requests
// that cannot matter (wrong dynode or side, channel, layer or bar out of range,
// unused action) and places the rest in a four-entry command queue, so the
// input keeps flowing while the back part is busy. The back part handles a load
// with one write to the pedestal RAM; a hit with the registered pedestal read
// plus the cut, then the compare and update of the layer maximum, overlapped
// with taking the next command; and an end of event by taking the command,
// forming the track flag, then sending one result per layer on results, layer
// 0 first, with last set on the final layer. Those per-layer results are what
// bound the rate; the pedestal RAM port and the hit compare set the pace of
// hits. A stalled results channel holds the back part while the queue still
// fills. The pedestal table needs no clearing pass: a hit on a channel that was
// never loaded is not supported. The threshold is to be written on cfg only
// while the block is idle; the block does not enforce this, and cfg_ready is
// always high.
module calorimeter_track_seed_core #(
  parameter int NUM_LAYERS   = cts_pkg::DEF_NUM_LAYERS,
  parameter int NUM_CHANNELS = cts_pkg::DEF_NUM_CHANNELS,
  parameter int NUM_BARS     = cts_pkg::DEF_NUM_BARS
) (
  input  logic                         clk,
  input  logic                         rst,
  cts_item_if.sink                     items,
  cts_result_if.source                 results,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cts_pkg::THRESH_W-1:0] cfg_data
);
  import cts_pkg::*;

  logic [THRESH_W-1:0] threshold;
  logic                push;
  cmd_t                push_cmd;
  logic                queue_full;
  logic                head_valid;
  cmd_t                head;
  logic                pop;

  // The threshold register takes every write; there is only one register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  cts_front #(
    .NUM_LAYERS   (NUM_LAYERS),
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_BARS     (NUM_BARS)
  ) u_front (
    .items      (items),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cts_back #(
    .NUM_LAYERS   (NUM_LAYERS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .cmd_valid (head_valid),
    .cmd       (head),
    .cmd_pop   (pop),
    .results   (results)
  );

endmodule

// ----- sv/cts_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cts_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/cts_front.sv -----
// Front part: accepts requests, drops those that cannot change anything,
// and turns the rest into commands for the queue. Depends on cts_pkg, cts_if.
module cts_front #(
  parameter int NUM_LAYERS   = cts_pkg::DEF_NUM_LAYERS,
  parameter int NUM_CHANNELS = cts_pkg::DEF_NUM_CHANNELS,
  parameter int NUM_BARS     = cts_pkg::DEF_NUM_BARS
) (
  cts_item_if.sink       items,
  input  logic           queue_full,
  output logic           push,
  output cts_pkg::cmd_t  push_cmd
);
  import cts_pkg::*;

  logic chan_ok;
  logic layer_ok;
  logic bar_ok;
  logic keep;

  assign chan_ok  = int'(items.channel) < NUM_CHANNELS;
  assign layer_ok = int'(items.layer) < NUM_LAYERS;
  assign bar_ok   = int'(items.bar) < NUM_BARS;

  // Only loads and hits that can touch state, and every end of event, go on.
  always_comb begin
    unique case (items.action)
      ACT_LOAD: keep = chan_ok;
      ACT_HIT:  keep = (items.dynode == USED_DYNODE) && !items.side &&
                       chan_ok && layer_ok && bar_ok;
      ACT_END:  keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign items.ready = !queue_full;
  assign push        = items.valid && !queue_full && keep;

  assign push_cmd.kind    = action_t'(items.action);
  assign push_cmd.channel = items.channel;
  assign push_cmd.layer   = items.layer;
  assign push_cmd.bar     = items.bar;
  assign push_cmd.adc     = items.adc;
  assign push_cmd.mean    = items.ped_mean;
  assign push_cmd.sigma   = items.ped_sigma;

endmodule

// ----- sv/cts_queue.sv -----
// Short command queue between the front and back parts.
// Depends on cts_pkg for the command type.
module cts_queue #(
  parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cts_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cts_pkg::cmd_t  head
);
  import cts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/cts_back.sv -----
// Back part: executes queued commands against the pedestal RAM and the
// per-layer maxima, and streams the per-layer results. Depends on cts_pkg,
// cts_if and cts_ram.
module cts_back #(
  parameter int NUM_LAYERS   = cts_pkg::DEF_NUM_LAYERS,
  parameter int NUM_CHANNELS = cts_pkg::DEF_NUM_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cts_pkg::THRESH_W-1:0] threshold,
  input  logic                         cmd_valid,
  input  cts_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  cts_result_if.source                 results
);
  import cts_pkg::*;

  localparam int ADDR_W = $clog2(NUM_CHANNELS);
  localparam int LIDX_W = $clog2(NUM_LAYERS);
  localparam logic [LIDX_W-1:0] LAST_IDX = LIDX_W'(NUM_LAYERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPD,
    ST_FLAG,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [AMP_W-1:0]  layer_max [NUM_LAYERS];
  logic [BAR_W-1:0]  layer_bar [NUM_LAYERS];
  logic [LIDX_W-1:0] emit_idx;
  logic              flag;

  logic [LIDX_W-1:0] hit_layer;
  logic [BAR_W-1:0]  hit_bar;
  logic [ADC_W-1:0]  hit_adc;
  logic              hit_pass;
  logic [AMP_W-1:0]  hit_amp;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [PED_W-1:0]  ram_rdata;
  logic [MEAN_W-1:0] rd_mean;
  logic [SIGMA_W-1:0] rd_sigma;
  logic [AMP_W-1:0]  adc_fx;
  logic [AMP_W-1:0]  cut;
  logic [AMP_W-1:0]  amp_calc;
  logic              pass_calc;
  logic              upd_take;
  logic [AMP_W-1:0]  thr_ext;
  logic              flag_calc;
  logic              out_free;

  assign cmd_pop  = cmd_valid && (state == ST_IDLE || state == ST_UPD);
  assign ram_we   = cmd_pop && (cmd.kind == ACT_LOAD);
  assign ram_re   = cmd_pop && (cmd.kind == ACT_HIT);
  assign ram_addr = ADDR_W'(cmd.channel);

  cts_ram #(
    .WIDTH (PED_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ped_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata ({cmd.mean, cmd.sigma}),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign rd_mean  = ram_rdata[SIGMA_W +: MEAN_W];
  assign rd_sigma = ram_rdata[SIGMA_W-1:0];

  // The ADC count is scaled to the pedestal's 1/16 units before the cut.
  assign adc_fx    = AMP_W'({hit_adc, {ADC_FRAC_W{1'b0}}});
  assign cut       = AMP_W'(rd_mean) + AMP_W'(rd_sigma) * SIGMA_FACTOR;
  assign pass_calc = adc_fx > cut;
  assign amp_calc  = adc_fx - AMP_W'(rd_mean);

  assign upd_take = hit_pass && (hit_amp > layer_max[hit_layer]);

  assign thr_ext   = AMP_W'(threshold);
  assign flag_calc = ((layer_max[0] > thr_ext) || (layer_max[1] > thr_ext)) &&
                     ((layer_max[NUM_LAYERS-2] > thr_ext) ||
                      (layer_max[NUM_LAYERS-1] > thr_ext));

  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      results.valid <= 1'b0;
      emit_idx      <= '0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
        layer_max[i] <= '0;
        layer_bar[i] <= '0;
      end
    end else begin
      // While emitting, the emit branch below sets valid on its own.
      if (results.valid && results.ready && state != ST_EMIT) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE, ST_UPD: begin
          if (state == ST_UPD && upd_take) begin
            layer_max[hit_layer] <= hit_amp;
            layer_bar[hit_layer] <= hit_bar;
          end
          if (cmd_pop) begin
            unique case (cmd.kind)
              ACT_HIT: begin
                hit_layer <= LIDX_W'(cmd.layer);
                hit_bar   <= cmd.bar;
                hit_adc   <= cmd.adc;
                state     <= ST_CALC;
              end
              ACT_END: state <= ST_FLAG;
              default: state <= ST_IDLE;
            endcase
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CALC: begin
          hit_pass <= pass_calc;
          hit_amp  <= amp_calc;
          state    <= ST_UPD;
        end
        ST_FLAG: begin
          flag     <= flag_calc;
          emit_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.out_layer   <= LAYER_W'(emit_idx);
            results.best_bar    <= layer_bar[emit_idx];
            results.track_found <= flag;
            results.last        <= emit_idx == LAST_IDX;
            layer_max[emit_idx] <= '0;
            layer_bar[emit_idx] <= '0;
            if (emit_idx == LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/cts_checker.sv -----
// Port-level checks on the result stream of the calorimeter track seed block,
// and the bind that attaches them to the top level. Depends on cts_pkg.
module cts_checker #(
  parameter int NUM_LAYERS = cts_pkg::DEF_NUM_LAYERS
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [cts_pkg::LAYER_W-1:0] res_layer,
  input logic [cts_pkg::BAR_W-1:0]   res_bar,
  input logic                        res_track,
  input logic                        res_last
);
  import cts_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable({res_layer, res_bar, res_track, res_last}))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown right after reset");

  a_last_layer: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_layer == LAYER_W'(NUM_LAYERS - 1))
    else $error("last flag on a layer other than the final one");

  // Within an event the layers come in order and share one track flag.
  a_layer_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=>
      !res_valid ||
      (res_layer == LAYER_W'($past(res_layer) + 1'b1) && res_track == $past(res_track)))
    else $error("layer results out of order or flag changed within an event");

endmodule

bind calorimeter_track_seed_core cts_checker #(
  .NUM_LAYERS (NUM_LAYERS)
) u_cts_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_layer (results.out_layer),
  .res_bar   (results.best_bar),
  .res_track (results.track_found),
  .res_last  (results.last)
);

// ----- bench/cts_track_seed_checker.sv -----
`timescale 1ns / 100ps
// Checker for the calorimeter track seed block: watches requests, threshold
// writes and layer results, predicts each result and compares it.
// Depends on cts_pkg and on the channel interfaces in cts_if.
module cts_track_seed_checker #(
  parameter int NUM_LAYERS   = cts_pkg::DEF_NUM_LAYERS,
  parameter int NUM_CHANNELS = cts_pkg::DEF_NUM_CHANNELS,
  parameter int NUM_BARS     = cts_pkg::DEF_NUM_BARS
) (
  input  logic                         clk,
  input  logic                         rst,
  cts_item_if                          items,
  cts_result_if                        results,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [cts_pkg::THRESH_W-1:0] cfg_data,
  output int unsigned                  fail_count,
  output int unsigned                  results_owed
);
  import cts_pkg::*;

  typedef struct packed {
    logic [LAYER_W-1:0] out_layer;
    logic [BAR_W-1:0]   best_bar;
    logic               track_found;
    logic               last;
  } layer_report_t;

  logic [MEAN_W-1:0]   ped_mean_copy  [NUM_CHANNELS];
  logic [SIGMA_W-1:0]  ped_sigma_copy [NUM_CHANNELS];
  logic [AMP_W-1:0]    peak_amp       [NUM_LAYERS];
  logic [BAR_W-1:0]    peak_bar       [NUM_LAYERS];
  logic [THRESH_W-1:0] end_threshold;
  layer_report_t       layer_reports_due[$];
  int unsigned         mismatches;

  initial begin
    fail_count   = 0;
    results_owed = 0;
    mismatches   = 0;
  end

  function automatic bit layer_over_threshold(int lyr);
    return peak_amp[lyr] > AMP_W'(end_threshold);
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Applies one accepted request to the predicted state; an end of event
  // queues one report per layer.
  task automatic track_seed_predict();
    logic [AMP_W-1:0] adc16;
    logic [AMP_W-1:0] cut;
    logic [AMP_W-1:0] amp;
    layer_report_t    rep;
    bit               flag;
    int               k;
    case (items.action)
      ACT_LOAD: begin
        if (items.channel < NUM_CHANNELS) begin
          ped_mean_copy[items.channel]  = items.ped_mean;
          ped_sigma_copy[items.channel] = items.ped_sigma;
        end
      end
      ACT_HIT: begin
        if (items.dynode == USED_DYNODE && items.side == 1'b0 &&
            items.channel < NUM_CHANNELS && items.layer < NUM_LAYERS &&
            items.bar < NUM_BARS) begin
          adc16 = AMP_W'(items.adc) << ADC_FRAC_W;
          cut   = AMP_W'(ped_mean_copy[items.channel]) +
                  SIGMA_FACTOR * AMP_W'(ped_sigma_copy[items.channel]);
          if (adc16 > cut) begin
            amp = adc16 - AMP_W'(ped_mean_copy[items.channel]);
            if (amp > peak_amp[items.layer]) begin
              peak_amp[items.layer] = amp;
              peak_bar[items.layer] = items.bar;
            end
          end
        end
      end
      ACT_END: begin
        flag = (layer_over_threshold(0) || layer_over_threshold(1)) &&
               (layer_over_threshold(NUM_LAYERS - 2) || layer_over_threshold(NUM_LAYERS - 1));
        for (k = 0; k < NUM_LAYERS; k++) begin
          rep.out_layer   = LAYER_W'(k);
          rep.best_bar    = peak_bar[k];
          rep.track_found = flag;
          rep.last        = (k == NUM_LAYERS - 1);
          layer_reports_due.push_back(rep);
          peak_amp[k] = '0;
          peak_bar[k] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_layer_report();
    layer_report_t want;
    if (layer_reports_due.size() == 0) begin
      $error("result with no expectation waiting: out_layer %0d best_bar %0d",
             results.out_layer, results.best_bar);
      mismatches++;
    end else begin
      want = layer_reports_due.pop_front();
      compare_field("out_layer", want.out_layer, results.out_layer);
      compare_field("best_bar", want.best_bar, results.best_bar);
      compare_field("track_found", want.track_found, results.track_found);
      compare_field("last", want.last, results.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      layer_reports_due.delete();
      for (int k = 0; k < NUM_LAYERS; k++) begin
        peak_amp[k] = '0;
        peak_bar[k] = '0;
      end
      end_threshold = THRESH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        end_threshold = cfg_data;
      end
      if (items.valid && items.ready) begin
        track_seed_predict();
      end
      if (results.valid && results.ready) begin
        check_layer_report();
      end
    end
    results_owed <= layer_reports_due.size();
    fail_count   <= mismatches;
  end

endmodule

// ----- bench/tb_calorimeter_track_seed_core.sv -----
`timescale 1ns / 100ps
// Testbench top for calorimeter_track_seed_core: drives requests and
// threshold writes, stalls the result side and gives the verdict.
// Depends on cts_pkg, cts_if, the block itself and cts_track_seed_checker.
module tb_calorimeter_track_seed_core;
  import cts_pkg::*;

  localparam int NUM_LAYERS   = DEF_NUM_LAYERS;
  localparam int NUM_CHANNELS = DEF_NUM_CHANNELS;
  localparam int NUM_BARS     = DEF_NUM_BARS;

  // Action code that the block must drop without a result.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Requests counted per random phase; together with the directed part, the
  // pedestal loads and the dropped requests, six phases come to roughly 400.
  localparam int PHASE_REQUESTS = 40;
  localparam int NUM_PHASES     = 6;
  // The back part may still chew on up to four queued hits after the last
  // result, so this many quiet cycles covers it with margin.
  localparam int SETTLE_CYCLES  = 40;
  // Long receiver hold-off used once to fill the command queue.
  localparam int HOLD_CYCLES    = 200;
  // The longest correct quiet stretch is the hold-off above plus a stalled ready segment; this is far past it.
  localparam int STALL_LIMIT    = 4000;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         results_owed;

  cts_item_if   items_ch();
  cts_result_if results_ch();

  calorimeter_track_seed_core #(
    .NUM_LAYERS  (NUM_LAYERS),
    .NUM_CHANNELS(NUM_CHANNELS),
    .NUM_BARS    (NUM_BARS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_ch),
    .results  (results_ch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  cts_track_seed_checker #(
    .NUM_LAYERS  (NUM_LAYERS),
    .NUM_CHANNELS(NUM_CHANNELS),
    .NUM_BARS    (NUM_BARS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .items       (items_ch),
    .results     (results_ch),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts consecutive cycles in which no request, no result and no
  // threshold write is accepted. A hung block ends the run as a failure.
  // ---------------------------------------------------------------------------
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("calorimeter_track_seed_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side. The ready pattern runs in segments of random length, each
  // one always ready, coin-flip ready, mostly stalled or fully stalled, so
  // stalls land on every layer of a report burst. When the stimulus bumps
  // hold_asked, the receiver holds off for HOLD_CYCLES counted here, which
  // lets the queue fill and pushes back on the request side.
  // ---------------------------------------------------------------------------
  int unsigned hold_asked = 0;

  initial begin
    int unsigned hold_served;
    int          seg_left;
    int          mode;
    hold_served = 0;
    seg_left    = 0;
    mode        = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 60);
      end
      seg_left--;
      case (mode)
        0: results_ch.ready <= 1'b1;
        1: results_ch.ready <= $urandom_range(0, 1);
        2: results_ch.ready <= ($urandom_range(0, 3) == 0);
        default: results_ch.ready <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Requests go out in bursts of random length; after each
  // burst the valid line may drop for a random gap. gaps_on switches the gaps
  // off while the queue is being filled against a stalled receiver.
  // The stimulus keeps its own record of which channels hold a pedestal so
  // that a hit that reaches the pedestal table never reads an unloaded entry,
  // and uses the loaded values to aim ADC counts around the cut.
  // ---------------------------------------------------------------------------
  int          loaded_channels[$];
  bit          channel_loaded [NUM_CHANNELS];
  int          ped_mean_seen  [NUM_CHANNELS];
  int          ped_sigma_seen [NUM_CHANNELS];
  int unsigned counted_requests = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;

  // Offers one request from the current clock edge and returns at the edge
  // where it was accepted, or after the idle gap that follows a burst.
  task automatic put_request(logic [ACTION_W-1:0] act, int ch, int lyr, int bar_no,
                             int dyn, bit sd, int adc_val, int mean, int sigma);
    int gap_len;
    items_ch.valid     <= 1'b1;
    items_ch.action    <= act;
    items_ch.channel   <= CHANNEL_W'(ch);
    items_ch.layer     <= LAYER_W'(lyr);
    items_ch.bar       <= BAR_W'(bar_no);
    items_ch.dynode    <= DYNODE_W'(dyn);
    items_ch.side      <= sd;
    items_ch.adc       <= ADC_W'(adc_val);
    items_ch.ped_mean  <= MEAN_W'(mean);
    items_ch.ped_sigma <= SIGMA_W'(sigma);
    do @(posedge clk); while (!items_ch.ready);
    if (act == ACT_LOAD || act == ACT_END ||
        (act == ACT_HIT && dyn == int'(USED_DYNODE) && !sd)) begin
      counted_requests++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      if (gap_len > 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic load_pedestal(int ch, int mean, int sigma);
    put_request(ACT_LOAD, ch, $urandom_range(0, 15), $urandom_range(0, 31),
                $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 65535),
                mean, sigma);
    ped_mean_seen[ch]  = mean;
    ped_sigma_seen[ch] = sigma;
    if (!channel_loaded[ch]) begin
      channel_loaded[ch] = 1'b1;
      loaded_channels.push_back(ch);
    end
  endtask

  // A hit that passes the dynode and side selection; the rest of its fields
  // that do not matter carry random values.
  task automatic send_hit(int ch, int lyr, int bar_no, int adc_val);
    put_request(ACT_HIT, ch, lyr, bar_no, USED_DYNODE, 1'b0, adc_val,
                $urandom_range(0, 20'hFFFFF), $urandom_range(0, 16'hFFFF));
  endtask

  task automatic end_event();
    put_request(ACT_END, $urandom_range(0, 2047), $urandom_range(0, 15),
                $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 1),
                $urandom_range(0, 65535), $urandom_range(0, 20'hFFFFF),
                $urandom_range(0, 16'hFFFF));
  endtask

  // Mostly modest pedestals so that hits pass the cut often; now and then a
  // pedestal with every field bit random.
  task automatic load_random_channel();
    if ($urandom_range(0, 5) == 0) begin
      load_pedestal($urandom_range(0, NUM_CHANNELS - 1), $urandom_range(0, 20'hFFFFF),
                    $urandom_range(0, 16'hFFFF));
    end else begin
      load_pedestal($urandom_range(0, NUM_CHANNELS - 1), $urandom_range(0, 4000),
                    $urandom_range(0, 300));
    end
  endtask

  // ADC count near the channel's cut, so that both sides of the cut and
  // amplitudes around the end threshold are common.
  function automatic int aimed_adc(int ch);
    int counts;
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 65535);
    end
    counts = (ped_mean_seen[ch] + int'(SIGMA_FACTOR) * ped_sigma_seen[ch]) >> ADC_FRAC_W;
    counts = counts + int'($urandom_range(0, 480)) - 40;
    if (counts < 0) begin
      return 0;
    end
    if (counts > 65535) begin
      return 65535;
    end
    return counts;
  endfunction

  // One event: a run of hits, mostly well formed and often on the end layers
  // that decide the track flag, mixed with pedestal reloads and requests the
  // block must drop. Most events close with an end of event; a few are left
  // open and merge into the next one.
  task automatic random_event();
    int n_hits;
    int ch;
    int lyr;
    int pick;
    n_hits = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
    repeat (n_hits) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        ch = loaded_channels[$urandom_range(0, loaded_channels.size() - 1)];
        case ($urandom_range(0, 3))
          0: lyr = 0;
          1: lyr = 1;
          2: lyr = NUM_LAYERS - 2 + $urandom_range(0, 1);
          default: lyr = $urandom_range(0, NUM_LAYERS - 1);
        endcase
        send_hit(ch, lyr, $urandom_range(0, NUM_BARS - 1), aimed_adc(ch));
      end else if (pick == 7) begin
        load_random_channel();
      end else begin
        // Dropped requests; none of them may reach the pedestal table, so
        // the channel may be one that was never loaded.
        ch = $urandom_range(0, NUM_CHANNELS - 1);
        case ($urandom_range(0, 4))
          0: put_request(ACT_HIT, ch, $urandom_range(0, 15), $urandom_range(0, 31),
                         (USED_DYNODE + $urandom_range(1, 15)) % 16, $urandom_range(0, 1),
                         $urandom_range(0, 65535), 0, 0);
          1: put_request(ACT_HIT, ch, $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, 15), 1'b1, $urandom_range(0, 65535), 0, 0);
          2: put_request(ACT_HIT, ch, $urandom_range(NUM_LAYERS, 15), $urandom_range(0, 31),
                         $urandom_range(0, 15), $urandom_range(0, 1),
                         $urandom_range(0, 65535), 0, 0);
          3: put_request(ACT_HIT, ch, $urandom_range(0, 15), $urandom_range(NUM_BARS, 31),
                         $urandom_range(0, 15), $urandom_range(0, 1),
                         $urandom_range(0, 65535), 0, 0);
          default: put_request(ACT_UNUSED, ch, $urandom_range(0, 15), $urandom_range(0, 31),
                               $urandom_range(0, 15), $urandom_range(0, 1),
                               $urandom_range(0, 65535), $urandom_range(0, 20'hFFFFF),
                               $urandom_range(0, 16'hFFFF));
        endcase
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      end_event();
    end
  endtask

  // Stops offering requests until every predicted layer report has come back,
  // then lets the block finish any hits still queued behind the last end.
  task automatic wait_results_drained();
    items_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [THRESH_W-1:0] thr;
    int unsigned         goal;
    int                  phase;
    int                  ch;

    rst                <= 1'b1;
    cfg_valid          <= 1'b0;
    cfg_data           <= '0;
    items_ch.valid     <= 1'b0;
    items_ch.action    <= ACT_LOAD;
    items_ch.channel   <= '0;
    items_ch.layer     <= '0;
    items_ch.bar       <= '0;
    items_ch.dynode    <= '0;
    items_ch.side      <= 1'b0;
    items_ch.adc       <= '0;
    items_ch.ped_mean  <= '0;
    items_ch.ped_sigma <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run at the reset threshold of 200.0.
    // Pedestals at both ends of the channel and value ranges, plus one
    // ordinary channel with mean 100.0 and sigma 10.0, so its cut is 130.0.
    load_pedestal(0, 0, 0);
    load_pedestal(NUM_CHANNELS - 1, 20'hFFFFF, 16'hFFFF);
    load_pedestal(5, 1600, 160);
    // Full-scale ADC on the first layer and the last bar.
    send_hit(0, 0, NUM_BARS - 1, 65535);
    // ADC exactly on the cut is rejected; one count above is kept.
    send_hit(5, NUM_LAYERS - 1, 3, 130);
    send_hit(5, NUM_LAYERS - 1, 4, 131);
    // An equal amplitude does not replace the kept bar.
    send_hit(5, NUM_LAYERS - 1, 7, 131);
    send_hit(0, NUM_LAYERS - 2, 0, 300);
    // Dropped hits: wrong dynode, side 1, layer and bar out of range, and
    // the unused action with every field bit set.
    put_request(ACT_HIT, 1234, 2, 1, 15, 1'b0, 65535, 0, 0);
    put_request(ACT_HIT, 0, 3, 1, USED_DYNODE, 1'b1, 65535, 0, 0);
    put_request(ACT_HIT, 0, 15, 10, USED_DYNODE, 1'b0, 65535, 0, 0);
    put_request(ACT_HIT, 0, 4, 31, USED_DYNODE, 1'b0, 65535, 0, 0);
    put_request(ACT_UNUSED, 2047, 15, 31, 15, 1'b1, 65535, 20'hFFFFF, 16'hFFFF);
    // Both ends above threshold: a track.
    end_event();
    // An event with no hits: every bar reads 0 and there is no track.
    end_event();
    // Front layer above threshold, back layer exactly at it: no track, but
    // the kept bars are still reported. The full-range pedestal never passes.
    send_hit(0, 1, 2, 201);
    send_hit(5, NUM_LAYERS - 1, 5, 300);
    send_hit(NUM_CHANNELS - 1, NUM_LAYERS - 1, 6, 65535);
    // Smallest amplitude that counts, and an ADC of zero that does not.
    send_hit(0, 0, 9, 1);
    send_hit(0, NUM_LAYERS - 1, 1, 0);
    end_event();

    // Random part in phases, each at its own threshold: the extremes, the
    // reset value and random values. The threshold is written only once the
    // block has gone quiet.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_results_drained();
      case (phase)
        0: thr = '0;
        1: thr = $urandom_range(1000, 6000);
        2: thr = '1;
        3: thr = $urandom_range(0, 20'hFFFFF);
        4: thr = $urandom_range(2000, 5000);
        default: thr = THRESH_RESET;
      endcase
      cfg_valid <= 1'b1;
      cfg_data  <= thr;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;

      repeat ((phase == 0) ? 16 : $urandom_range(4, 10)) load_random_channel();

      if (phase == 1) begin
        // Hold the receiver off and keep offering hits and ends of event back
        // to back, so the queue fills and the request side stalls.
        hold_asked <= hold_asked + 1;
        gaps_on = 1'b0;
        repeat (8) begin
          ch = loaded_channels[$urandom_range(0, loaded_channels.size() - 1)];
          send_hit(ch, $urandom_range(0, 1), $urandom_range(0, NUM_BARS - 1), aimed_adc(ch));
          end_event();
        end
        gaps_on = 1'b1;
      end

      goal = counted_requests + PHASE_REQUESTS;
      while (counted_requests < goal) begin
        random_event();
      end
      end_event();
    end

    wait_results_drained();
    if (fail_count == 0) begin
      $display("calorimeter_track_seed_core verification clean");
    end else begin
      $display("calorimeter_track_seed_core verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/cts_pkg.sv
sv/cts_if.sv
sv/cts_ram.sv
sv/cts_front.sv
sv/cts_queue.sv
sv/cts_back.sv
sv/calorimeter_track_seed_core.sv
sv/cts_checker.sv
bench/cts_track_seed_checker.sv
bench/tb_calorimeter_track_seed_core.sv
